### hdl/ci_adapter_register_block_defines.svh
// Assertion macros shared by the register block RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CI_ADAPTER_REGISTER_BLOCK_DEFINES_SVH
`define CI_ADAPTER_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check.
`define CIRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check.
`define CIRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CIRB_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define CIRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/cirb_pkg.sv
// Package for the adapter register block: register map, command bits, ring layout,
// sequencer state type and default parameter values. No dependencies.
package cirb_pkg;

   // Field widths of the channels.
   localparam int REG_IDX_W   = 6;
   localparam int DATA_W      = 16;
   localparam int DESC_ADDR_W = 22;
   localparam int DESC_LEN_W  = 10;

   // Ring word storage.
   localparam int RING_WORDS  = 56;
   localparam int RING_ADDR_W = 6;

   // Scan index covers the largest ring (eight entries).
   localparam int IDX_W = 3;

   // Default entry counts of the two send rings.
   localparam int SEND_LO_ENTRIES_DEF = 8;
   localparam int SEND_HI_ENTRIES_DEF = 4;

   // Non-volatile store.
   localparam int NV_WORDS  = 16;
   localparam int NV_IDX_W  = 4;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_CONTROL    = 6'd0;
   localparam logic [REG_IDX_W-1:0] REG_STATUS     = 6'd1;
   localparam logic [REG_IDX_W-1:0] REG_WIN_LO     = 6'd5;
   localparam logic [REG_IDX_W-1:0] REG_WIN_HI     = 6'd6;
   localparam logic [REG_IDX_W-1:0] REG_WIN_DATA   = 6'd7;
   localparam logic [REG_IDX_W-1:0] REG_RING_FIRST = 6'd8;

   // Control register command bits, highest priority first.
   localparam int CMD_READ_MEM   = 15;
   localparam int CMD_WRITE_MEM  = 14;
   localparam int CMD_WRITE_NV   = 13;
   localparam int CMD_INIT       = 4;
   localparam int CMD_START      = 5;
   localparam int CMD_RUNDOWN    = 6;
   localparam int CMD_HALT       = 7;
   localparam int CMD_SEND_HI    = 0;
   localparam int CMD_SEND_LO    = 1;

   // Status word bit positions.
   localparam int STAT_INIT = 4;
   localparam int STAT_RUN  = 5;

   // Memory window of the non-volatile store.
   localparam logic [31:0] NV_BASE = 32'h0017_8000;
   localparam logic [31:0] NV_END  = 32'h0017_8200;
   localparam int          OP_DONE = 31;

   // First ring word of each send ring, counted from register index 8.
   localparam logic [RING_ADDR_W-1:0] HI_WORD_BASE = 6'd0;
   localparam logic [RING_ADDR_W-1:0] LO_WORD_BASE = 6'd8;

   // Bit positions inside the high half of a ring entry.
   localparam int ENT_OWNED_BIT = 15;
   localparam int ENT_LEN_HI    = 13;
   localparam int ENT_LEN_LO    = 6;
   localparam int ENT_ADDR_HI   = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_EMIT,
      ST_RD_LO,
      ST_RD_HI,
      ST_CHECK,
      ST_WB_HI,
      ST_FINISH
   } state_type;

endpackage

### hdl/cirb_req_if.sv
// Request channel of the register block: one register access per beat.
// Depends on cirb_pkg for field widths.
interface cirb_req_if import cirb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [REG_IDX_W-1:0] reg_index;
   logic [DATA_W-1:0]    write_data;

   modport source (output valid, kind, reg_index, write_data, input ready);
   modport sink   (input valid, kind, reg_index, write_data, output ready);
endinterface

### hdl/cirb_rsp_if.sv
// Response channel of the register block: one result per beat.
// Depends on cirb_pkg for field widths.
interface cirb_rsp_if import cirb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DATA_W-1:0]      read_data;
   logic                   desc_valid;
   logic [DESC_ADDR_W-1:0] desc_addr;
   logic [DESC_LEN_W-1:0]  desc_length;
   logic                   last;

   modport source (output valid, read_data, desc_valid, desc_addr, desc_length, last,
                   input ready);
   modport sink   (input valid, read_data, desc_valid, desc_addr, desc_length, last,
                   output ready);
endinterface

### hdl/cirb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cirb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ci_adapter_register_block.sv
// Top level of the adapter register block: register decode, command sequencer and ring scan.
// Depends on cirb_pkg, cirb_req_if, cirb_rsp_if, cirb_ram and the assertion macro header.
//
//   Channel   Direction  Beat carries
//   req_bus   in         kind, reg_index, write_data (one register access)
//   rsp_bus   out        read_data, desc_valid, desc_addr, desc_length, last
//
// A plain register access passes through the decode and emit states before its result stands
// in the output register; a read of a ring word adds a wait state for the RAM's registered port.
// A send attention reads each ring entry in the read-low, read-high and check states and adds
// a write-back state per owned entry; the single RAM read port, one ring word a cycle, paces it.
// Reset is synchronous and active high. The ring words are cleared by per-word valid bits,
// so there is no clearing pass and the block is ready for requests once reset is released.
// A result waiting in the output register stalls the scan only when a further result must
// be pushed out; requests are taken again as soon as the sequencer returns to idle.
`include "ci_adapter_register_block_defines.svh"

module ci_adapter_register_block import cirb_pkg::*; #(
   parameter int SEND_LO_ENTRIES = SEND_LO_ENTRIES_DEF,
   parameter int SEND_HI_ENTRIES = SEND_HI_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cirb_req_if.sink   req_bus,
   cirb_rsp_if.source rsp_bus
);

   // Sequencer state.
   state_type state_ff, state_in;

   // Captured request.
   logic                 kind_ff, kind_in;
   logic [REG_IDX_W-1:0] reg_ff, reg_in;
   logic [DATA_W-1:0]    data_ff, data_in;

   // Architectural registers. The status word only ever holds its init and run bits.
   logic                 init_ff, init_in;
   logic                 run_ff, run_in;
   logic [31:0]          win_addr_ff, win_addr_in;
   logic [DATA_W-1:0]    win_data_ff, win_data_in;
   logic [DATA_W-1:0]    nv_ff [NV_WORDS];
   logic [DATA_W-1:0]    nv_in [NV_WORDS];
   logic                 ring_valid_ff [RING_WORDS];
   logic                 ring_valid_in [RING_WORDS];
   logic                 rd_valid_ff;

   // Scan context.
   logic                   hi_ring_ff, hi_ring_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [DATA_W-1:0]      lo_word_ff, lo_word_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [DESC_ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [DESC_LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic [DATA_W-1:0]      res_data_ff, res_data_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_read_data_ff, rsp_read_data_in;
   logic                   rsp_desc_valid_ff, rsp_desc_valid_in;
   logic [DESC_ADDR_W-1:0] rsp_desc_addr_ff, rsp_desc_addr_in;
   logic [DESC_LEN_W-1:0]  rsp_desc_length_ff, rsp_desc_length_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Ring RAM port.
   logic                   ram_wr_en;
   logic [RING_ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0]      ram_wr_data;
   logic [RING_ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0]      ram_rd_data;
   logic [DATA_W-1:0]      ram_q;

   // Derived values.
   logic                   out_free;
   logic                   req_take;
   logic                   in_window;
   logic [NV_IDX_W-1:0]    nv_idx;
   logic [RING_ADDR_W-1:0] ring_base;
   logic [RING_ADDR_W-1:0] scan_word;
   logic [RING_ADDR_W-1:0] scan_word_hi;
   logic [RING_ADDR_W-1:0] reg_word;
   logic [IDX_W-1:0]       entries_m1;
   logic                   last_entry;
   logic [DATA_W-1:0]      status_word;

   cirb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RING_WORDS)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The output register is free when empty or when its beat leaves in this cycle.
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take  = req_bus.valid && req_bus.ready;

   // The store answers only when the whole 32-bit address lies inside its window; the
   // op-complete bit, once set, therefore keeps the address out of the window.
   assign in_window = (win_addr_ff >= NV_BASE) && (win_addr_ff < NV_END);
   assign nv_idx    = win_addr_ff[NV_IDX_W:1];

   // Ring words that were never written read as zero.
   assign ram_q = rd_valid_ff ? ram_rd_data : '0;

   // Entry i of a ring sits at words base + 2i (low half) and base + 2i + 1 (high half).
   assign ring_base    = hi_ring_ff ? HI_WORD_BASE : LO_WORD_BASE;
   assign scan_word    = ring_base + {{(RING_ADDR_W-IDX_W-1){1'b0}}, idx_ff, 1'b0};
   assign scan_word_hi = scan_word + RING_ADDR_W'(1);
   assign entries_m1   = hi_ring_ff ? IDX_W'(SEND_HI_ENTRIES - 1) : IDX_W'(SEND_LO_ENTRIES - 1);
   assign last_entry   = (idx_ff == entries_m1);
   assign reg_word     = reg_ff - REG_RING_FIRST;

   always_comb begin
      status_word            = '0;
      status_word[STAT_INIT] = init_ff;
      status_word[STAT_RUN]  = run_ff;
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      reg_in        = reg_ff;
      data_in       = data_ff;
      init_in       = init_ff;
      run_in        = run_ff;
      win_addr_in   = win_addr_ff;
      win_data_in   = win_data_ff;
      nv_in         = nv_ff;
      ring_valid_in = ring_valid_ff;
      hi_ring_in    = hi_ring_ff;
      idx_in        = idx_ff;
      lo_word_in    = lo_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_len_in   = pend_len_ff;
      res_data_in   = res_data_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = scan_word;
      ram_wr_data = '0;
      ram_rd_addr = scan_word;

      // The output register drains on its own; a load below overrides this.
      rsp_valid_in       = rsp_valid_ff && !rsp_bus.ready;
      rsp_read_data_in   = rsp_read_data_ff;
      rsp_desc_valid_in  = rsp_desc_valid_ff;
      rsp_desc_addr_in   = rsp_desc_addr_ff;
      rsp_desc_length_in = rsp_desc_length_ff;
      rsp_last_in        = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in  = req_bus.kind;
               reg_in   = req_bus.reg_index;
               data_in  = req_bus.write_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_data_in = '0;
            state_in    = ST_EMIT;
            if (!kind_ff) begin
               // Register read.
               if (reg_ff >= REG_RING_FIRST) begin
                  ram_rd_addr = reg_word;
                  state_in    = ST_RD_WAIT;
               end else begin
                  case (reg_ff)
                     REG_STATUS:   res_data_in = status_word;
                     REG_WIN_LO:   res_data_in = win_addr_ff[15:0];
                     REG_WIN_HI:   res_data_in = win_addr_ff[31:16];
                     REG_WIN_DATA: res_data_in = win_data_ff;
                     default:      res_data_in = '0;
                  endcase
               end
            end else if (reg_ff >= REG_RING_FIRST) begin
               ram_wr_en                = 1'b1;
               ram_wr_addr              = reg_word;
               ram_wr_data              = data_ff;
               ring_valid_in[reg_word]  = 1'b1;
            end else begin
               case (reg_ff)
                  REG_CONTROL: begin
                     // Only the first set command, in priority order, is run.
                     if (data_ff[CMD_READ_MEM]) begin
                        win_data_in          = in_window ? nv_ff[nv_idx] : '0;
                        win_addr_in[OP_DONE] = 1'b1;
                     end else if (data_ff[CMD_WRITE_MEM]) begin
                        if (in_window) begin
                           nv_in[nv_idx] = win_data_ff;
                        end
                        win_addr_in[OP_DONE] = 1'b1;
                     end else if (data_ff[CMD_WRITE_NV]) begin
                        win_addr_in[OP_DONE] = 1'b1;
                     end else if (data_ff[CMD_INIT]) begin
                        init_in = 1'b1;
                     end else if (data_ff[CMD_START]) begin
                        run_in = 1'b1;
                     end else if (data_ff[CMD_RUNDOWN]) begin
                        run_in = 1'b0;
                     end else if (data_ff[CMD_HALT]) begin
                        init_in = 1'b0;
                        run_in  = 1'b0;
                     end else if (data_ff[CMD_SEND_HI]) begin
                        hi_ring_in = 1'b1;
                        idx_in     = '0;
                        state_in   = ST_RD_LO;
                     end else if (data_ff[CMD_SEND_LO]) begin
                        hi_ring_in = 1'b0;
                        idx_in     = '0;
                        state_in   = ST_RD_LO;
                     end
                  end
                  REG_WIN_LO:   win_addr_in[15:0]  = data_ff;
                  REG_WIN_HI:   win_addr_in[31:16] = data_ff;
                  REG_WIN_DATA: win_data_in        = data_ff;
                  default: begin
                     // Remaining low registers ignore writes.
                  end
               endcase
            end
         end

         ST_RD_WAIT: begin
            res_data_in = ram_q;
            state_in    = ST_EMIT;
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_read_data_in   = res_data_ff;
               rsp_desc_valid_in  = 1'b0;
               rsp_desc_addr_in   = '0;
               rsp_desc_length_in = '0;
               rsp_last_in        = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         ST_RD_LO: begin
            ram_rd_addr = scan_word;
            state_in    = ST_RD_HI;
         end

         ST_RD_HI: begin
            ram_rd_addr = scan_word_hi;
            lo_word_in  = ram_q;
            state_in    = ST_CHECK;
         end

         ST_CHECK: begin
            // Keep the high half on the RAM output while a stall lasts.
            ram_rd_addr = scan_word_hi;
            if (ram_q[ENT_OWNED_BIT]) begin
               if (!pend_valid_ff || out_free) begin
                  // The held descriptor is now known not to be the final one.
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_read_data_in   = '0;
                     rsp_desc_valid_in  = 1'b1;
                     rsp_desc_addr_in   = pend_addr_ff;
                     rsp_desc_length_in = pend_len_ff;
                     rsp_last_in        = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_addr_in  = {ram_q[ENT_ADDR_HI:0], lo_word_ff};
                  pend_len_in   = {ram_q[ENT_LEN_HI:ENT_LEN_LO], 2'b00};
                  // Write back the low half; it holds only address bits.
                  ram_wr_en                = 1'b1;
                  ram_wr_addr              = scan_word;
                  ram_wr_data              = lo_word_ff;
                  ring_valid_in[scan_word] = 1'b1;
                  state_in                 = ST_WB_HI;
               end
            end else if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_RD_LO;
            end
         end

         ST_WB_HI: begin
            ram_wr_en                   = 1'b1;
            ram_wr_addr                 = scan_word_hi;
            ram_wr_data                 = {{(DATA_W-ENT_ADDR_HI-1){1'b0}},
                                           pend_addr_ff[DESC_ADDR_W-1:DATA_W]};
            ring_valid_in[scan_word_hi] = 1'b1;
            if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_RD_LO;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_read_data_in   = '0;
               rsp_desc_valid_in  = pend_valid_ff;
               rsp_desc_addr_in   = pend_valid_ff ? pend_addr_ff : '0;
               rsp_desc_length_in = pend_valid_ff ? pend_len_ff : '0;
               rsp_last_in        = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         init_ff       <= 1'b0;
         run_ff        <= 1'b0;
         win_addr_ff   <= '0;
         win_data_ff   <= '0;
         for (int i = 0; i < NV_WORDS; i++) begin
            nv_ff[i] <= '0;
         end
         for (int i = 0; i < RING_WORDS; i++) begin
            ring_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         init_ff       <= init_in;
         run_ff        <= run_in;
         win_addr_ff   <= win_addr_in;
         win_data_ff   <= win_data_in;
         nv_ff         <= nv_in;
         ring_valid_ff <= ring_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff            <= kind_in;
      reg_ff             <= reg_in;
      data_ff            <= data_in;
      hi_ring_ff         <= hi_ring_in;
      idx_ff             <= idx_in;
      lo_word_ff         <= lo_word_in;
      pend_addr_ff       <= pend_addr_in;
      pend_len_ff        <= pend_len_in;
      res_data_ff        <= res_data_in;
      rd_valid_ff        <= ring_valid_ff[ram_rd_addr];
      rsp_read_data_ff   <= rsp_read_data_in;
      rsp_desc_valid_ff  <= rsp_desc_valid_in;
      rsp_desc_addr_ff   <= rsp_desc_addr_in;
      rsp_desc_length_ff <= rsp_desc_length_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.read_data   = rsp_read_data_ff;
   assign rsp_bus.desc_valid  = rsp_desc_valid_ff;
   assign rsp_bus.desc_addr   = rsp_desc_addr_ff;
   assign rsp_bus.desc_length = rsp_desc_length_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // A held descriptor only exists while a ring scan is under way.
   `CIRB_ASSERT_NOW(a_pend_in_scan, clock, reset, pend_valid_ff, (state_ff == ST_RD_LO || state_ff == ST_RD_HI || state_ff == ST_CHECK || state_ff == ST_WB_HI || state_ff == ST_FINISH), "descriptor held outside a ring scan")
   // Descriptor beats never carry read data.
   `CIRB_ASSERT_NOW(a_desc_no_data, clock, reset, rsp_valid_ff && rsp_desc_valid_ff, rsp_read_data_ff == '0, "descriptor beat with read data")
   // The scan index stays inside the ring being serviced.
   `CIRB_ASSERT_NOW(a_idx_in_ring, clock, reset, (state_ff == ST_RD_LO || state_ff == ST_RD_HI || state_ff == ST_CHECK || state_ff == ST_WB_HI), idx_ff <= entries_m1, "scan index beyond ring")
   // A memory read command always leaves op-complete set.
   `CIRB_ASSERT_NEXT(a_read_mem_done, clock, reset, (state_ff == ST_DECODE && kind_ff && reg_ff == REG_CONTROL && data_ff[CMD_READ_MEM]), win_addr_ff[OP_DONE], "memory read left op-complete clear")

endmodule
